[hw/rtl/imu_sa_pkg.sv]
// Shared types and constants for the IMU sliding-average filter.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package imu_sa_pkg;

  // Window and channel layout
  localparam int Window   = 30;
  localparam int NumCh    = 10;
  localparam int NumQuat  = 4;
  localparam int QuatBase = 6;
  localparam int ChW      = 16;
  localparam int MinFill  = 3;

  // Derived widths
  localparam int CntW     = $clog2(Window + 1);
  localparam int SlotW    = $clog2(Window);
  localparam int SumW     = ChW + $clog2(Window);
  localparam int QIdxW    = $clog2(NumQuat);
  localparam int NormW    = 2 * ChW + 1;          // sum of four squares
  localparam int FracSh   = 28;                   // Q1.14 squared
  localparam int RootW    = ChW + 15;             // floor(sqrt(N << 28))
  localparam int RadW     = 2 * RootW;            // radicand register
  localparam int RemW     = NormW + 2;            // root remainder
  localparam int QBits    = 16;                   // normalize quotient bits
  localparam int StepW    = $clog2(RootW);
  localparam int QuatOne  = 16384;

  typedef logic [NumCh-1:0][ChW-1:0] sample_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             capture;
    logic             update;
    logic             div_init;
    logic             div_step;
    logic             sq_clr;
    logic             sq_step;
    logic [QIdxW-1:0] sq_idx;
    logic             rt_init;
    logic             rt_step;
    logic             nd_init;
    logic             nd_step;
    logic             out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic smooth_next;
    logic norm_zero;
  } status_t;

endpackage

[hw/rtl/imu_sa_ctrl.sv]
// Controller state machine of the IMU sliding-average filter.
// Depends on imu_sa_pkg; drives the datapath through cmd_t.
`timescale 1ns / 1ps

module imu_sa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  imu_sa_pkg::status_t status_i,
  output imu_sa_pkg::cmd_t    cmd_o
);
  import imu_sa_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_UPD   = 10'b0000000010,
    S_DINIT = 10'b0000000100,
    S_DIV   = 10'b0000001000,
    S_SQ    = 10'b0000010000,
    S_CHECK = 10'b0000100000,
    S_ROOT  = 10'b0001000000,
    S_NINIT = 10'b0010000000,
    S_NDIV  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             ovalid_q, ovalid_d;

  // Next state, step counter and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = status_i.smooth_next ? S_DINIT : S_DONE;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        cmd_o.sq_clr   = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == StepW'(SumW - 1)) begin
          cnt_d   = '0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq_step = 1'b1;
        cmd_o.sq_idx  = cnt_q[QIdxW-1:0];
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == StepW'(NumQuat - 1)) begin
          cnt_d   = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.norm_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rt_init = 1'b1;
          state_d       = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd_o.rt_step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == StepW'(RootW - 1)) begin
          cnt_d   = '0;
          state_d = S_NINIT;
        end
      end
      S_NINIT: begin
        cmd_o.nd_init = 1'b1;
        state_d       = S_NDIV;
      end
      S_NDIV: begin
        cmd_o.nd_step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == StepW'(QBits - 1)) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result word until taken
  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.out_load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

endmodule

[hw/rtl/imu_sa_dp.sv]
// Datapath of the IMU sliding-average filter: sample ring, running sums,
// count divider lanes, square accumulator, square root and normalize lanes.
// Depends on imu_sa_pkg.
`timescale 1ns / 1ps

module imu_sa_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  imu_sa_pkg::cmd_t    cmd_i,
  output imu_sa_pkg::status_t status_o,
  input  imu_sa_pkg::sample_t in_data_i,
  output imu_sa_pkg::sample_t out_data_o,
  output logic                out_smooth_o
);
  import imu_sa_pkg::*;

  localparam int AddW = CntW + 1;

  // Ring and window state
  sample_t                mem [Window];
  sample_t                rd_q;
  sample_t                sample_q;
  logic signed [SumW-1:0] sums_q [NumCh];
  logic [CntW-1:0]        fill_q;
  logic [SlotW-1:0]       oldest_q;
  logic                   smooth_q;
  logic                   full;
  logic [AddW-1:0]        slot_sum;
  logic [SlotW-1:0]       wr_slot;

  // Divider lanes
  logic [SumW-1:0]        dq_q   [NumCh];
  logic [CntW-1:0]        drem_q [NumCh];
  logic                   dneg_q [NumCh];
  logic signed [ChW-1:0]  avg    [NumCh];

  // Norm, root and normalize lanes
  logic [NormW-1:0]       nsum_q;
  logic [ChW-1:0]         sq_mag;
  logic [2*ChW-1:0]       sq_prod;
  logic [RadW-1:0]        rx_q;
  logic [RemW-1:0]        rrem_q;
  logic [RootW-1:0]       root_q;
  logic [RemW-1:0]        rt_rem2;
  logic [RemW-1:0]        rt_trial;
  logic [RootW:0]         nrem_q [NumQuat];
  logic [QBits-1:0]       nq_q   [NumQuat];
  logic [ChW-1:0]         qmag   [NumQuat];
  logic signed [ChW-1:0]  qnorm  [NumQuat];
  sample_t                out_q;
  logic                   out_smooth_q;

  assign full = (fill_q == CntW'(Window));

  // Pick the slot for the new sample
  always_comb begin
    slot_sum = AddW'(oldest_q) + AddW'(fill_q);
    if (slot_sum >= AddW'(Window)) begin
      slot_sum = slot_sum - AddW'(Window);
    end
    wr_slot = full ? oldest_q : slot_sum[SlotW-1:0];
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= in_data_i;
    end
  end

  // Sample ring: one write port, one registered read of the oldest slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      mem[wr_slot] <= sample_q;
    end
    rd_q <= mem[oldest_q];
  end

  // Running sums, fill count and ring pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCh; i++) begin
        sums_q[i] <= '0;
      end
      fill_q   <= '0;
      oldest_q <= '0;
      smooth_q <= 1'b0;
    end else if (cmd_i.update) begin
      for (int i = 0; i < NumCh; i++) begin
        sums_q[i] <= sums_q[i] + SumW'($signed(sample_q[i]))
                   - (full ? SumW'($signed(rd_q[i])) : SumW'(0));
      end
      if (full) begin
        oldest_q <= (oldest_q == SlotW'(Window - 1)) ? '0 : oldest_q + 1'b1;
      end else begin
        fill_q <= fill_q + 1'b1;
      end
      smooth_q <= status_o.smooth_next;
    end
  end

  assign status_o.smooth_next = full || (fill_q >= CntW'(MinFill - 1));
  assign status_o.norm_zero   = (nsum_q == '0);

  // Divide each sum magnitude by the fill count, one bit per cycle
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumCh; i++) begin
      logic [AddW-1:0] r2;
      r2 = {drem_q[i], dq_q[i][SumW-1]};
      if (cmd_i.div_init) begin
        dneg_q[i] <= sums_q[i][SumW-1];
        dq_q[i]   <= sums_q[i][SumW-1] ? SumW'(-sums_q[i]) : SumW'(sums_q[i]);
        drem_q[i] <= '0;
      end else if (cmd_i.div_step) begin
        if (r2 >= AddW'(fill_q)) begin
          drem_q[i] <= CntW'(r2 - AddW'(fill_q));
          dq_q[i]   <= {dq_q[i][SumW-2:0], 1'b1};
        end else begin
          drem_q[i] <= CntW'(r2);
          dq_q[i]   <= {dq_q[i][SumW-2:0], 1'b0};
        end
      end
    end
  end

  // Apply sign to the averages and take the quaternion magnitudes
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      avg[i] = dneg_q[i] ? ChW'(-dq_q[i]) : ChW'(dq_q[i]);
    end
    for (int k = 0; k < NumQuat; k++) begin
      qmag[k] = avg[QuatBase+k][ChW-1] ? ChW'(-avg[QuatBase+k])
                                       : ChW'(avg[QuatBase+k]);
    end
  end

  // Accumulate the squared quaternion components, one per cycle
  assign sq_mag  = qmag[cmd_i.sq_idx];
  assign sq_prod = sq_mag * sq_mag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_clr) begin
      nsum_q <= '0;
    end else if (cmd_i.sq_step) begin
      nsum_q <= nsum_q + NormW'(sq_prod);
    end
  end

  // Square root of the norm shifted up, two radicand bits per cycle
  assign rt_rem2  = {rrem_q[RemW-3:0], rx_q[RadW-1 -: 2]};
  assign rt_trial = RemW'({root_q, 2'b01});

  always_ff @(posedge clk_i) begin
    if (cmd_i.rt_init) begin
      rx_q   <= RadW'({nsum_q, FracSh'(0)});
      rrem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.rt_step) begin
      rx_q <= {rx_q[RadW-3:0], 2'b00};
      if (rt_rem2 >= rt_trial) begin
        rrem_q <= rt_rem2 - rt_trial;
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rrem_q <= rt_rem2;
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
  end

  // Normalize lanes: (mag << 28) / root, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumQuat; k++) begin
      logic [RootW:0] r2;
      r2 = {nrem_q[k][RootW-1:0], 1'b0};
      if (cmd_i.nd_init) begin
        nrem_q[k] <= (RootW+1)'(qmag[k]) << (FracSh - QBits);
        nq_q[k]   <= '0;
      end else if (cmd_i.nd_step) begin
        if (r2 >= (RootW+1)'(root_q)) begin
          nrem_q[k] <= r2 - (RootW+1)'(root_q);
          nq_q[k]   <= {nq_q[k][QBits-2:0], 1'b1};
        end else begin
          nrem_q[k] <= r2;
          nq_q[k]   <= {nq_q[k][QBits-2:0], 1'b0};
        end
      end
    end
  end

  // Clamp to one and restore the sign
  always_comb begin
    for (int k = 0; k < NumQuat; k++) begin
      logic [QBits-1:0] q;
      q = (nq_q[k] > QBits'(QuatOne)) ? QBits'(QuatOne) : nq_q[k];
      qnorm[k] = avg[QuatBase+k][ChW-1] ? ChW'(-q) : ChW'(q);
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_smooth_q <= smooth_q;
      for (int i = 0; i < NumCh; i++) begin
        if (!smooth_q) begin
          out_q[i] <= sample_q[i];
        end else if (i >= QuatBase && !status_o.norm_zero) begin
          out_q[i] <= qnorm[i-QuatBase];
        end else begin
          out_q[i] <= avg[i];
        end
      end
    end
  end

  assign out_data_o   = out_q;
  assign out_smooth_o = out_smooth_q;

endmodule

[hw/rtl/imu_sliding_average.sv]
// Top level of the IMU sliding-average filter.
// Depends on imu_sa_pkg, imu_sa_ctrl and imu_sa_dp.
`timescale 1ns / 1ps

// One input word carries ten signed 16-bit channels (accel, rate, Q1.14
// quaternion). The last 30 samples are kept in a ring; once three or more
// are held the result is the per-channel average truncated toward zero, with
// the averaged quaternion normalized to unit length, and tuser is 1;
// otherwise the sample passes through and tuser is 0. An averaged word goes
// through the per-channel count division, the squared norm, the bit-serial
// square root and the normalize division; the last two are skipped when the
// averaged quaternion is zero. One word is processed at a time; the next word
// may be accepted while the previous result waits on the output.
module imu_sliding_average (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
  // quat_x, quat_y, quat_z, quat_w (16 bits each, from bit 0 up)
  input  logic [159:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_accel_x, out_accel_y, out_accel_z, out_rate_x, out_rate_y, out_rate_z,
  // out_quat_x, out_quat_y, out_quat_z, out_quat_w (16 bits each, from bit 0 up)
  output logic [159:0] m_axis_tdata_o,
  // smoothed
  output logic         m_axis_tuser_o
);
  import imu_sa_pkg::*;

  cmd_t    cmd;
  status_t status;
  sample_t out_data;

  imu_sa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  imu_sa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_data_i    (sample_t'(s_axis_tdata_i)),
    .out_data_o   (out_data),
    .out_smooth_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = out_data;

endmodule
